[src/sqlun_pkg.sv]
// shared types, byte codes and classification functions for the sql space normalizer
package sqlun_pkg;

  localparam int MAX_TAG_LEN_DEF = 32;
  localparam int RES_SLOTS = 3;

  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_UNDER  = 8'h5F;

  localparam logic [7:0] U_C2 = 8'hC2;
  localparam logic [7:0] U_A0 = 8'hA0;
  localparam logic [7:0] U_E2 = 8'hE2;
  localparam logic [7:0] U_80 = 8'h80;
  localparam logic [7:0] U_8B = 8'h8B;
  localparam logic [7:0] U_AF = 8'hAF;
  localparam logic [7:0] U_81 = 8'h81;
  localparam logic [7:0] U_9F = 8'h9F;
  localparam logic [7:0] U_E3 = 8'hE3;
  localparam logic [7:0] U_EF = 8'hEF;
  localparam logic [7:0] U_BB = 8'hBB;
  localparam logic [7:0] U_BF = 8'hBF;

  typedef enum logic [2:0] {
    MODE_REGULAR = 3'd0,
    MODE_QUOTE   = 3'd1,
    MODE_TAG     = 3'd2,
    MODE_DOLLAR  = 3'd3,
    MODE_COMMENT = 3'd4
  } scan_mode_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       repl;
  } res_t;

  function automatic logic tag_first_ok(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) ||
           c == CH_UNDER || c >= 8'h80;
  endfunction

  function automatic logic tag_next_ok(input logic [7:0] c);
    return tag_first_ok(c) || (c >= 8'h30 && c <= 8'h39);
  endfunction

  function automatic logic is_space3(input logic [7:0] a, input logic [7:0] b,
                                     input logic [7:0] c);
    return (a == U_E2 && b == U_80 && ((c >= U_80 && c <= U_8B) || c == U_AF)) ||
           (a == U_E2 && b == U_81 && (c == U_9F || c == U_A0)) ||
           (a == U_E3 && b == U_80 && c == U_80) ||
           (a == U_EF && b == U_BB && c == U_BF);
  endfunction

endpackage

[src/sqlun_scan.sv]
// lookahead window, context tracking, dollar tag store and per-beat result build
module sqlun_scan
  import sqlun_pkg::*;
#(
  parameter int MAX_TAG_LEN = MAX_TAG_LEN_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     fire,
  input  logic [7:0]               data_byte,
  input  logic                     last_byte,
  output logic [1:0]               res_cnt,
  output res_t [RES_SLOTS-1:0]     res
);

  localparam int LW = $clog2(MAX_TAG_LEN + 1);
  localparam int MW = $clog2(MAX_TAG_LEN + 2);
  localparam int AW = (MAX_TAG_LEN > 1) ? $clog2(MAX_TAG_LEN) : 1;

  scan_mode_t mode_r, mode_nxt;
  logic [7:0] held_r [2];
  logic [7:0] held_nxt [2];
  logic [1:0] held_cnt_r, held_cnt_nxt;
  logic [7:0] quote_r, quote_nxt;
  logic [LW-1:0] tag_len_r, tag_len_nxt;
  logic [MW-1:0] match_r, match_nxt;
  logic replaced_r, replaced_nxt;

  logic [7:0] tag_mem [MAX_TAG_LEN];
  logic [7:0] tag_rd_r;
  logic [MW-1:0] rd_src;
  logic [MW-1:0] rd_dec;
  logic       mem_we;

  logic       proc;
  logic       do_regular;
  logic       tag_ok;
  logic [7:0] b, w1, w2;
  logic [7:0] emit;
  logic [1:0] used;
  logic [7:0] rem0, rem1;
  logic [1:0] rem_cnt;
  logic [MW-1:0] len_ext;

  assign b       = held_r[0];
  assign w1      = held_r[1];
  assign w2      = data_byte;
  assign proc    = (held_cnt_r == 2'd2);
  assign len_ext = MW'(tag_len_r);
  assign tag_ok  = tag_next_ok(b) && (tag_len_r < LW'(MAX_TAG_LEN));

  always_comb begin
    mode_nxt     = mode_r;
    quote_nxt    = quote_r;
    tag_len_nxt  = tag_len_r;
    match_nxt    = match_r;
    replaced_nxt = replaced_r;
    held_nxt     = held_r;
    held_cnt_nxt = held_cnt_r;
    mem_we       = 1'b0;
    emit         = b;
    used         = 2'd1;
    do_regular   = (mode_r == MODE_REGULAR) ||
                   (mode_r == MODE_TAG && b != CH_DOLLAR && !tag_ok);
    res          = '0;
    res_cnt      = 2'd0;
    rem0         = data_byte;
    rem1         = data_byte;
    rem_cnt      = 2'd0;

    if (proc) begin
      if (do_regular) begin
        mode_nxt = MODE_REGULAR;
        if (b == U_C2 && w1 == U_A0) begin
          replaced_nxt = 1'b1;
          emit         = CH_SPACE;
          used         = 2'd2;
        end else if (is_space3(b, w1, w2)) begin
          replaced_nxt = 1'b1;
          emit         = CH_SPACE;
          used         = 2'd3;
        end else if (b == CH_DQUOTE || b == CH_SQUOTE) begin
          quote_nxt = b;
          mode_nxt  = MODE_QUOTE;
        end else if (b == CH_DOLLAR && (w1 == CH_DOLLAR || tag_first_ok(w1))) begin
          mode_nxt    = MODE_TAG;
          tag_len_nxt = '0;
        end else if (b == CH_DASH && w1 == CH_DASH) begin
          mode_nxt = MODE_COMMENT;
        end
      end else begin
        unique case (mode_r)
          MODE_QUOTE: begin
            if (b == quote_r) mode_nxt = MODE_REGULAR;
          end
          MODE_TAG: begin
            if (b == CH_DOLLAR) begin
              mode_nxt  = MODE_DOLLAR;
              match_nxt = MW'(1);
            end else begin
              mem_we      = 1'b1;
              tag_len_nxt = tag_len_r + LW'(1);
            end
          end
          MODE_DOLLAR: begin
            if (match_r != '0 && match_r <= len_ext) begin
              if (b == tag_rd_r) match_nxt = match_r + MW'(1);
              else match_nxt = (b == CH_DOLLAR) ? MW'(1) : '0;
            end else if (match_r == len_ext + MW'(1)) begin
              match_nxt = '0;
              if (b == CH_DOLLAR) mode_nxt = MODE_REGULAR;
            end else begin
              match_nxt = (b == CH_DOLLAR) ? MW'(1) : '0;
            end
          end
          default: begin
            if (b == CH_LF || b == CH_CR) mode_nxt = MODE_REGULAR;
          end
        endcase
      end
      unique case (used)
        2'd1: begin
          rem0    = w1;
          rem1    = w2;
          rem_cnt = 2'd2;
        end
        2'd2: begin
          rem0    = w2;
          rem_cnt = 2'd1;
        end
        default: rem_cnt = 2'd0;
      endcase
      res[0].data = emit;
      res[1].data = rem0;
      res[2].data = rem1;
    end else begin
      if (held_cnt_r == 2'd1) begin
        rem0    = held_r[0];
        rem1    = data_byte;
        rem_cnt = 2'd2;
      end else begin
        rem0    = data_byte;
        rem_cnt = 2'd1;
      end
      res[0].data = rem0;
      res[1].data = rem1;
      res[2].data = rem1;
    end

    if (last_byte) begin
      res_cnt = 2'(proc) + rem_cnt;
      unique case (res_cnt)
        2'd1: begin
          res[0].last = 1'b1;
          res[0].repl = replaced_nxt;
        end
        2'd2: begin
          res[1].last = 1'b1;
          res[1].repl = replaced_nxt;
        end
        default: begin
          res[2].last = 1'b1;
          res[2].repl = replaced_nxt;
        end
      endcase
      mode_nxt     = MODE_REGULAR;
      quote_nxt    = '0;
      tag_len_nxt  = '0;
      match_nxt    = '0;
      replaced_nxt = 1'b0;
      held_cnt_nxt = 2'd0;
    end else begin
      res_cnt      = 2'(proc);
      held_cnt_nxt = rem_cnt;
      held_nxt[0]  = rem0;
      held_nxt[1]  = rem1;
    end
  end

  assign rd_src = fire ? match_nxt : match_r;
  assign rd_dec = rd_src - MW'(1);

  always_ff @(posedge clk) begin
    if (fire && mem_we) tag_mem[tag_len_r[AW-1:0]] <= b;
    tag_rd_r <= tag_mem[rd_dec[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_REGULAR;
      held_cnt_r <= 2'd0;
      quote_r    <= '0;
      tag_len_r  <= '0;
      match_r    <= '0;
      replaced_r <= 1'b0;
    end else if (fire) begin
      mode_r     <= mode_nxt;
      held_cnt_r <= held_cnt_nxt;
      quote_r    <= quote_nxt;
      tag_len_r  <= tag_len_nxt;
      match_r    <= match_nxt;
      replaced_r <= replaced_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      held_r[0] <= held_nxt[0];
      held_r[1] <= held_nxt[1];
    end
  end

  a_held_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    held_cnt_r != 2'd3)
    else $error("held byte count out of range");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    fire && last_byte |=> held_cnt_r == 2'd0 && mode_r == MODE_REGULAR && !replaced_r)
    else $error("state not cleared after final beat");

  a_tag_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    tag_len_r <= LW'(MAX_TAG_LEN))
    else $error("tag length beyond limit");

  a_match_bound: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r == MODE_DOLLAR |-> match_r <= len_ext + MW'(1))
    else $error("tag match count beyond closing delimiter");

endmodule

[src/sqlun_outbuf.sv]
// result register holding up to three beats from one input byte, drained one per cycle while out_ready is high
module sqlun_outbuf
  import sqlun_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  logic [1:0]           load_cnt,
  input  res_t [RES_SLOTS-1:0] load_res,
  output logic                 can_load,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           out_byte,
  output logic                 out_last,
  output logic                 out_any_replaced
);

  res_t [RES_SLOTS-1:0] slot_r;
  logic [1:0]           cnt_r;
  logic                 pop;

  assign out_valid        = (cnt_r != 2'd0);
  assign pop              = out_valid && out_ready;
  assign can_load         = (cnt_r == 2'd0) || (cnt_r == 2'd1 && out_ready);
  assign out_byte         = slot_r[0].data;
  assign out_last         = slot_r[0].last;
  assign out_any_replaced = slot_r[0].repl;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else if (load) begin
      cnt_r <= load_cnt;
    end else if (pop) begin
      cnt_r <= cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      slot_r <= load_res;
    end else if (pop) begin
      slot_r[0] <= slot_r[1];
      slot_r[1] <= slot_r[2];
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    load && cnt_r != 2'd0 |-> pop && cnt_r == 2'd1)
    else $error("result beats overwritten before delivery");

  a_last_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> cnt_r == 2'd1)
    else $error("final beat not at tail of buffer");

  a_repl_only_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_any_replaced |-> out_last)
    else $error("replaced flag on a non-final beat");

endmodule

[src/sql_unicode_space_normalizer.sv]
// Streams SQL text one UTF-8 byte per beat and replaces Unicode space sequences outside
// quotes, dollar quotes and line comments with a single ASCII space. A byte is decided once
// two bytes after it are in hand, so output trails input by up to two bytes; the beat
// marked last flushes the held bytes and carries the replaced flag. Throughput is one input
// byte per cycle while out_ready holds: each byte is registered, decided by one window
// compare and one tag store read, and its results land in a three-slot output register. A
// final byte that yields two or three result beats holds the input while the slots drain.
module sql_unicode_space_normalizer
  import sqlun_pkg::*;
#(
  parameter int MAX_TAG_LEN = MAX_TAG_LEN_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       in_last_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_last,
  output logic       out_any_replaced
);

  logic       in_v_r;
  logic [7:0] in_data_r;
  logic       in_last_r;
  logic       can_load;
  logic       fire;
  logic [1:0] res_cnt;
  res_t [RES_SLOTS-1:0] res;

  assign fire     = in_v_r && can_load;
  assign in_ready = !in_v_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ready) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_data_r <= in_data_byte;
      in_last_r <= in_last_byte;
    end
  end

  sqlun_scan #(
    .MAX_TAG_LEN(MAX_TAG_LEN)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .data_byte (in_data_r),
    .last_byte (in_last_r),
    .res_cnt   (res_cnt),
    .res       (res)
  );

  sqlun_outbuf u_outbuf (
    .clk              (clk),
    .rst_n            (rst_n),
    .load             (fire),
    .load_cnt         (res_cnt),
    .load_res         (res),
    .can_load         (can_load),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_byte         (out_byte),
    .out_last         (out_last),
    .out_any_replaced (out_any_replaced)
  );

endmodule
